[hw/rtl/stable_priority_queue_unit_assert.svh]
// ----------------------------------------------------------------------------
// stable priority queue assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`else

`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// types and constants shared by the stable priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DepthDef = 16;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic               func;
    logic signed [31:0] item_value;
    logic        [7:0]  item_priority;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] head_value;
    logic        [7:0]  head_priority;
    logic        [4:0]  occupancy;
  } res_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [7:0]  prio;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctrl_t;

endpackage

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted queue; inserts, shifts right on insert, left on removal
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  entry_t     left_i,
  input  logic       left_gt_i,
  input  entry_t     right_i,
  output entry_t     slot_o,
  output logic       gt_o
);

  entry_t slot_q, slot_d;

  // empty slots count as holding a larger number, keeps the flags monotonic
  assign gt_o   = !occ_i || (slot_q.prio > ctrl_i.item.prio);
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.enq) begin
      if (gt_o) begin
        slot_d = left_gt_i ? left_i : ctrl_i.item;
      end
    end else if (ctrl_i.deq) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

[hw/rtl/stable_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// bounded priority queue kept sorted in a row of cells, ties leave in order
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// request   in         start_i, busy_o        req_i  (func, item_value, item_priority)
// result    out        done_o (one cycle)     res_o  (status, head_value,
//                                                     head_priority, occupancy)
//
// one transaction per cycle: every cell compares and shifts in parallel, so busy_o
// stays low and the result appears with done_o in the cycle after start_i.
// reset clears the fill count and done_o only; slot contents and res_o are not cleared.
// the result register is overwritten every cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stable_priority_queue_unit_assert.svh"

module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  res_t            res_q, res_d;

  logic            accept, is_enq, full, empty, enq_ok, deq_ok;
  cell_ctrl_t      ctrl;
  entry_t          slot   [DEPTH];
  logic            gt     [DEPTH];
  logic            occ    [DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign is_enq = (req_i.func == FUNC_ENQ);
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign enq_ok = accept && is_enq && !full;
  assign deq_ok = accept && !is_enq && !empty;

  assign ctrl.enq        = enq_ok;
  assign ctrl.deq        = deq_ok;
  assign ctrl.item.value = req_i.item_value;
  assign ctrl.item.prio  = req_i.item_priority;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .occ_i     (occ[i]),
        .left_i    (ctrl.item),
        .left_gt_i (1'b0),
        .right_i   (slot[(DEPTH > 1) ? 1 : 0]),
        .slot_o    (slot[i]),
        .gt_o      (gt[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .occ_i     (occ[i]),
        .left_i    (slot[i-1]),
        .left_gt_i (gt[i-1]),
        .right_i   (slot[i]),
        .slot_o    (slot[i]),
        .gt_o      (gt[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .occ_i     (occ[i]),
        .left_i    (slot[i-1]),
        .left_gt_i (gt[i-1]),
        .right_i   (slot[i+1]),
        .slot_o    (slot[i]),
        .gt_o      (gt[i])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CntW'(1);
    end else if (deq_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    res_d.status        = STAT_DONE;
    res_d.head_value    = '0;
    res_d.head_priority = '0;
    res_d.occupancy     = 5'(count_d);
    if (is_enq) begin
      if (full) begin
        res_d.status = STAT_OVERFLOW;
      end
    end else if (empty) begin
      res_d.status = STAT_UNDERFLOW;
    end else begin
      res_d.head_value    = slot[0].value;
      res_d.head_priority = slot[0].prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `SPQ_ASSERT_NXT(a_done_follows, clk_i, rst_ni, accept, done_o)
  `SPQ_ASSERT_NXT(a_no_spurious_done, clk_i, rst_ni, !accept, !done_o)
  `SPQ_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(DEPTH))
  `SPQ_ASSERT_IMP(a_overflow_full, clk_i, rst_ni,
                  done_o && (res_o.status == STAT_OVERFLOW), count_q == CntW'(DEPTH))
  `SPQ_ASSERT_IMP(a_underflow_empty, clk_i, rst_ni,
                  done_o && (res_o.status == STAT_UNDERFLOW), count_q == '0)

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// stable priority queue testbench
// drives enqueue and dequeue transactions into the queue, with random gaps
// between them, and checks each result against a written expectation or a
// behavioral copy of the sorted store, where ties leave in arrival order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import spq_pkg::*;
;

  localparam int unsigned DEPTH = DepthDef;
  localparam int RandItems = 850;
  localparam int QuietTail = 150;
  localparam int CycleLimit = 40000;

  typedef struct {
    req_t req;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;

  // behavioral copy of the sorted store
  entry_t store_slot [DEPTH+1];
  int     store_fill = 0;

  res_t      pending_results [$];
  stim_row_t stim_rows [$];
  int        mismatches = 0;
  int        cycles = 0;
  res_t      oldest;

  stable_priority_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // applies one transaction to the store copy and returns its result
  function automatic res_t queue_op_outcome(req_t r);
    res_t o;
    int   pos;
    int   k;
    o = '0;
    o.status = STAT_DONE;
    if (r.func == FUNC_ENQ) begin
      if (store_fill >= DEPTH) begin
        o.status = STAT_OVERFLOW;
      end else begin
        // goes behind every entry of equal or lower number
        pos = 0;
        while (pos < store_fill && store_slot[pos].prio <= r.item_priority) pos++;
        for (k = store_fill; k > pos; k--) store_slot[k] = store_slot[k-1];
        store_slot[pos].value = r.item_value;
        store_slot[pos].prio = r.item_priority;
        store_fill++;
      end
    end else if (store_fill == 0) begin
      o.status = STAT_UNDERFLOW;
    end else begin
      o.head_value = store_slot[0].value;
      o.head_priority = store_slot[0].prio;
      for (k = 0; k < store_fill - 1; k++) store_slot[k] = store_slot[k+1];
      store_fill--;
    end
    o.occupancy = 5'(store_fill);
    return o;
  endfunction

  function automatic req_t enq(logic signed [31:0] v, logic [7:0] p);
    req_t r;
    r.func = FUNC_ENQ;
    r.item_value = v;
    r.item_priority = p;
    return r;
  endfunction

  function automatic req_t deq();
    req_t r;
    r.func = FUNC_DEQ;
    r.item_value = $urandom;
    r.item_priority = 8'($urandom);
    return r;
  endfunction

  task automatic add_row(req_t r, bit typed, res_t want);
    stim_row_t row;
    row.req = r;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  // presents one transaction and holds it until the queue takes it
  task automatic issue(req_t r, bit typed, res_t want, bit may_idle);
    res_t predicted;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    predicted = queue_op_outcome(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        oldest = pending_results.pop_front();
        if (res_o.status !== oldest.status)
          report_mismatch($sformatf("status got %0d want %0d", res_o.status, oldest.status));
        if (res_o.head_value !== oldest.head_value)
          report_mismatch($sformatf("head_value got %0h want %0h",
                                    res_o.head_value, oldest.head_value));
        if (res_o.head_priority !== oldest.head_priority)
          report_mismatch($sformatf("head_priority got %0d want %0d",
                                    res_o.head_priority, oldest.head_priority));
        if (res_o.occupancy !== oldest.occupancy)
          report_mismatch($sformatf("occupancy got %0d want %0d",
                                    res_o.occupancy, oldest.occupancy));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int   enq_pct;
    int   mode_left;
    int   pick;
    req_t r;
    logic [7:0] p;

    // empty queue, then a full fill with ties at both priority extremes
    add_row(deq(), 1'b1, res_t'{STAT_UNDERFLOW, 32'sd0, 8'd0, 5'd0});
    add_row(enq(32'sh7FFFFFFF, 8'd0), 1'b1, res_t'{STAT_DONE, 32'sd0, 8'd0, 5'd1});
    add_row(enq(32'sh80000000, 8'd255), 1'b0, '0);
    add_row(enq(-32'sd1, 8'd128), 1'b0, '0);
    add_row(enq(32'sd0, 8'd0), 1'b0, '0);
    add_row(enq(32'sd1, 8'd255), 1'b0, '0);
    add_row(enq(32'sh55555555, 8'd128), 1'b0, '0);
    add_row(enq(32'shAAAAAAAA, 8'd1), 1'b0, '0);
    add_row(enq(32'sh12345678, 8'd254), 1'b0, '0);
    add_row(enq(-32'sd2, 8'd0), 1'b0, '0);
    add_row(enq(32'sh0F0F0F0F, 8'd85), 1'b0, '0);
    add_row(enq(32'shF0F0F0F0, 8'd170), 1'b0, '0);
    add_row(enq(32'sd3, 8'd128), 1'b0, '0);
    add_row(enq(32'sd4, 8'd255), 1'b0, '0);
    add_row(enq(32'sd5, 8'd1), 1'b0, '0);
    add_row(enq(32'sd6, 8'd127), 1'b0, '0);
    add_row(enq(32'sd7, 8'd0), 1'b0, '0);
    add_row(enq(32'sd99, 8'd0), 1'b1, res_t'{STAT_OVERFLOW, 32'sd0, 8'd0, 5'd16});
    add_row(deq(), 1'b1, res_t'{STAT_DONE, 32'sh7FFFFFFF, 8'd0, 5'd15});
    repeat (5) add_row(deq(), 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) issue(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want, 1'b1);

    // random part: the enqueue share switches between draining, balanced and
    // filling so the occupancy sweeps between empty and full
    enq_pct = 50;
    mode_left = 0;
    for (int n = 0; n < RandItems; n++) begin
      if (mode_left == 0) begin
        pick = $urandom_range(0, 2);
        enq_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      pick = $urandom_range(0, 9);
      if (pick < 6) p = 8'($urandom_range(0, 3));
      else if (pick < 9) p = 8'($urandom_range(0, 255));
      else p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      if ($urandom_range(0, 99) < enq_pct) r = enq($urandom, p);
      else r = deq();
      issue(r, 1'b0, '0, n < RandItems - QuietTail);
    end
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
